@@ rtl/ats_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types of the alias table sampler.
package ats_pkg;

  // Default sizes
  localparam int unsigned MAX_ITEMS_DEF   = 256;
  localparam int unsigned TABLE_DEPTH_DEF = 512;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Fixed field widths
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RAND_W   = 16;
  localparam int unsigned SIDX_W   = 8;
  localparam int unsigned CTOT_W   = 10;

  // Opcodes of an input item
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Kinds of a result item
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store one weight
    logic capture;    // latch sample random inputs
    logic scan_init;  // start a build: clear stacks and cells
    logic w_read;     // read the weight at the scan index
    logic next_i;     // advance the scan index
    logic mul;        // form weight times count and load the divider
    logic div_step;   // one quotient bit
    logic push;       // push the score on the poor or rich stack
    logic pop_read;   // read both stack tops
    logic step;       // make one cell
    logic report;     // load a build report into the output register
    logic samp_read;  // read the chosen cell
    logic samp_out;   // load a sample result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic in_opcode;
    logic in_last;
    logic sum_zero;
    logic scan_done;
    logic w_zero;
    logic div_done;
    logic stacks_empty;
    logic table_full;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/ats_in_if.sv @@
// Input channel of the alias table sampler: valid/ready with one input item.
interface ats_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [ats_pkg::WEIGHT_W-1:0]  weight;
  logic                          last_weight;
  logic [ats_pkg::RAND_W-1:0]    rand_slot;
  logic [ats_pkg::RAND_W-1:0]    rand_coin;

  modport source (output valid, opcode, weight, last_weight, rand_slot, rand_coin,
                  input ready);
  modport sink   (input valid, opcode, weight, last_weight, rand_slot, rand_coin,
                  output ready);
endinterface

@@ rtl/ats_out_if.sv @@
// Output channel of the alias table sampler: valid/ready with one result item.
interface ats_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [ats_pkg::SIDX_W-1:0]  sample_index;
  logic                        table_empty;
  logic [ats_pkg::CTOT_W-1:0]  cell_total;
  logic                        overflow;

  modport source (output valid, result_kind, sample_index, table_empty, cell_total,
                  overflow, input ready);
  modport sink   (input valid, result_kind, sample_index, table_empty, cell_total,
                  overflow, output ready);
endinterface

@@ rtl/ats_ctrl.sv @@
// Controller state machine of the alias table sampler.
module ats_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ats_pkg::sts_t sts_i,
  output ats_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BINIT  = 4'd1;
  localparam logic [3:0] ST_BRD    = 4'd2;
  localparam logic [3:0] ST_BMUL   = 4'd3;
  localparam logic [3:0] ST_BDIV   = 4'd4;
  localparam logic [3:0] ST_BPUSH  = 4'd5;
  localparam logic [3:0] ST_BPOP   = 4'd6;
  localparam logic [3:0] ST_BSTEP  = 4'd7;
  localparam logic [3:0] ST_REPORT = 4'd8;
  localparam logic [3:0] ST_SADDR  = 4'd9;
  localparam logic [3:0] ST_SOUT   = 4'd10;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (sts_i.in_valid) begin
          if (sts_i.in_opcode == ats_pkg::OP_SAMPLE) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SADDR;
          end else begin
            cmd_o.load = 1'b1;
            if (sts_i.in_last) state_d = ST_BINIT;
          end
        end
      end
      ST_BINIT: begin
        cmd_o.scan_init = 1'b1;
        state_d = sts_i.sum_zero ? ST_REPORT : ST_BRD;
      end
      ST_BRD: begin
        if (sts_i.scan_done) begin
          state_d = ST_BPOP;
        end else begin
          cmd_o.w_read = 1'b1;
          state_d      = ST_BMUL;
        end
      end
      ST_BMUL: begin
        if (sts_i.w_zero) begin
          cmd_o.next_i = 1'b1;
          state_d      = ST_BRD;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_BDIV;
        end
      end
      ST_BDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_BPUSH;
      end
      ST_BPUSH: begin
        cmd_o.push   = 1'b1;
        cmd_o.next_i = 1'b1;
        state_d      = ST_BRD;
      end
      ST_BPOP: begin
        if (sts_i.stacks_empty) begin
          state_d = ST_REPORT;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = ST_BSTEP;
        end
      end
      ST_BSTEP: begin
        cmd_o.step = 1'b1;
        state_d = sts_i.table_full ? ST_REPORT : ST_BPOP;
      end
      ST_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SADDR: begin
        cmd_o.samp_read = 1'b1;
        state_d         = ST_SOUT;
      end
      ST_SOUT: begin
        if (sts_i.out_free) begin
          cmd_o.samp_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/ats_datapath.sv @@
// Datapath of the alias table sampler: weight store, divider, stacks, alias table, output register.
module ats_datapath #(
  parameter int unsigned MAX_ITEMS   = ats_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TABLE_DEPTH = ats_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = ats_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ats_pkg::cmd_t                cmd_i,
  output ats_pkg::sts_t                sts_o,
  input  logic                         in_valid_i,
  input  logic                         opcode_i,
  input  logic [ats_pkg::WEIGHT_W-1:0] weight_i,
  input  logic                         last_weight_i,
  input  logic [ats_pkg::RAND_W-1:0]   rand_slot_i,
  input  logic [ats_pkg::RAND_W-1:0]   rand_coin_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output logic [ats_pkg::SIDX_W-1:0]   sample_index_o,
  output logic                         table_empty_o,
  output logic [ats_pkg::CTOT_W-1:0]   cell_total_o,
  output logic                         overflow_o
);

  localparam int unsigned WW      = ats_pkg::WEIGHT_W;
  localparam int unsigned RW      = ats_pkg::RAND_W;
  localparam int unsigned IDX_W   = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W   = WW + CNT_W;
  localparam int unsigned SCORE_W = CNT_W + FRAC_BITS;
  localparam int unsigned DIVD_W  = WW + CNT_W + FRAC_BITS;
  localparam int unsigned BIT_W   = $clog2(DIVD_W);
  localparam int unsigned THR_W   = FRAC_BITS + 1;
  localparam int unsigned TADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CCNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PAIR_W  = IDX_W + SCORE_W;
  localparam int unsigned CELL_W  = IDX_W + THR_W + IDX_W + 1;
  localparam int unsigned COIN_W  = RW + FRAC_BITS;

  localparam logic [SCORE_W-1:0] ONE_S     = SCORE_W'(1) << FRAC_BITS;
  localparam logic [THR_W-1:0]   ONE_T     = THR_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]   MAX_C     = CNT_W'(MAX_ITEMS);
  localparam logic [CCNT_W-1:0]  DEPTH_C   = CCNT_W'(TABLE_DEPTH);
  localparam logic [BIT_W-1:0]   BIT_LAST  = BIT_W'(DIVD_W - 1);

  // Storage
  logic [WW-1:0]     wmem   [MAX_ITEMS];
  logic [PAIR_W-1:0] poor_m [MAX_ITEMS];
  logic [PAIR_W-1:0] rich_m [MAX_ITEMS];
  logic [CELL_W-1:0] tbl_m  [TABLE_DEPTH];

  // Control registers
  logic [CNT_W-1:0]  item_cnt_q, item_cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              ovf_q, ovf_d;
  logic [CCNT_W-1:0] cell_cnt_q, cell_cnt_d;
  logic [CNT_W-1:0]  scan_i_q, scan_i_d;
  logic [CNT_W-1:0]  np_q, np_d, nr_q, nr_d;
  logic [BIT_W-1:0]  bit_q;
  logic              out_valid_q;

  // Payload registers
  logic [WW-1:0]      w_rd_q;
  logic [DIVD_W-1:0]  dvd_q;
  logic [SUM_W-1:0]   rem_q;
  logic [SCORE_W-1:0] quo_q;
  logic [RW-1:0]      rslot_q, rcoin_q;
  logic [PAIR_W-1:0]  poor_rd_q, rich_rd_q;
  logic [CELL_W-1:0]  cell_rd_q;
  logic               kind_q, empty_q, ovf_out_q;
  logic [ats_pkg::SIDX_W-1:0] sidx_q;
  logic [ats_pkg::CTOT_W-1:0] ctot_q;

  // Divider step
  logic [SUM_W:0]     trial;
  logic               ge;
  logic [SUM_W-1:0]   rem_next;
  logic [WW+CNT_W-1:0] prod;

  assign trial    = {rem_q, dvd_q[DIVD_W-1]};
  assign ge       = trial >= {1'b0, sum_q};
  assign rem_next = ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
  assign prod     = w_rd_q * item_cnt_q;

  // Stack tops
  logic [IDX_W-1:0]   p_idx, r_idx;
  logic [SCORE_W-1:0] p_score, r_score, rem_s, r_left;
  logic               have_p, have_r, full;

  assign p_idx   = poor_rd_q[PAIR_W-1 -: IDX_W];
  assign p_score = poor_rd_q[SCORE_W-1:0];
  assign r_idx   = rich_rd_q[PAIR_W-1 -: IDX_W];
  assign r_score = rich_rd_q[SCORE_W-1:0];
  assign have_p  = np_q != '0;
  assign have_r  = nr_q != '0;
  assign full    = cell_cnt_q >= DEPTH_C;
  assign rem_s   = have_p ? ONE_S - p_score : ONE_S;
  assign r_left  = r_score - rem_s;

  // Stack and table write ports
  logic               poor_we, rich_we, cell_we;
  logic [IDX_W-1:0]   poor_wa, rich_wa;
  logic [PAIR_W-1:0]  poor_wd, rich_wd;
  logic [CELL_W-1:0]  cell_wd;

  // Build sequencing: pushes, cell steps and counters
  always_comb begin
    np_d       = np_q;
    nr_d       = nr_q;
    cell_cnt_d = cell_cnt_q;
    poor_we    = 1'b0;
    rich_we    = 1'b0;
    cell_we    = 1'b0;
    poor_wa    = '0;
    rich_wa    = '0;
    poor_wd    = '0;
    rich_wd    = '0;
    cell_wd    = '0;
    if (cmd_i.scan_init) begin
      np_d       = '0;
      nr_d       = '0;
      cell_cnt_d = '0;
    end else if (cmd_i.push) begin
      if (quo_q <= ONE_S) begin
        poor_we = 1'b1;
        poor_wa = np_q[IDX_W-1:0];
        poor_wd = {scan_i_q[IDX_W-1:0], quo_q};
        np_d    = np_q + 1'b1;
      end else begin
        rich_we = 1'b1;
        rich_wa = nr_q[IDX_W-1:0];
        rich_wd = {scan_i_q[IDX_W-1:0], quo_q};
        nr_d    = nr_q + 1'b1;
      end
    end else if (cmd_i.step && !full) begin
      cell_we    = 1'b1;
      cell_cnt_d = cell_cnt_q + 1'b1;
      if (have_p && rem_s == '0) begin
        // exact fill: no alias
        cell_wd = {p_idx, ONE_T, {IDX_W{1'b0}}, 1'b0};
        np_d    = np_q - 1'b1;
      end else if (have_r) begin
        cell_wd = have_p ? {p_idx, THR_W'(p_score), r_idx, 1'b1}
                         : {r_idx, ONE_T, {IDX_W{1'b0}}, 1'b0};
        if (r_left > ONE_S) begin
          // rich stays rich: rewrite its slot
          rich_we = 1'b1;
          rich_wa = IDX_W'(nr_q - 1'b1);
          rich_wd = {r_idx, r_left};
          np_d    = have_p ? np_q - 1'b1 : np_q;
        end else begin
          poor_we = 1'b1;
          poor_wa = have_p ? IDX_W'(np_q - 1'b1) : np_q[IDX_W-1:0];
          poor_wd = {r_idx, r_left};
          np_d    = have_p ? np_q : np_q + 1'b1;
          nr_d    = nr_q - 1'b1;
        end
      end else begin
        // poor with no rich left becomes a full cell
        cell_wd = {p_idx, ONE_T, {IDX_W{1'b0}}, 1'b0};
        np_d    = np_q - 1'b1;
      end
    end
  end

  // Load accounting and overflow
  always_comb begin
    item_cnt_d = item_cnt_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    scan_i_d   = scan_i_q;
    if (cmd_i.load) begin
      if (item_cnt_q == '0) ovf_d = 1'b0;
      if (item_cnt_q < MAX_C) begin
        item_cnt_d = item_cnt_q + 1'b1;
        sum_d      = sum_q + SUM_W'(weight_i);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.step && full) ovf_d = 1'b1;
    if (cmd_i.report) begin
      item_cnt_d = '0;
      sum_d      = '0;
    end
    if (cmd_i.scan_init) scan_i_d = '0;
    else if (cmd_i.next_i) scan_i_d = scan_i_q + 1'b1;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cnt_q  <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      cell_cnt_q  <= '0;
      scan_i_q    <= '0;
      np_q        <= '0;
      nr_q        <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      item_cnt_q <= item_cnt_d;
      sum_q      <= sum_d;
      ovf_q      <= ovf_d;
      cell_cnt_q <= cell_cnt_d;
      scan_i_q   <= scan_i_d;
      np_q       <= np_d;
      nr_q       <= nr_d;
      if (cmd_i.mul) bit_q <= '0;
      else if (cmd_i.div_step) bit_q <= bit_q + 1'b1;
      if (cmd_i.report || cmd_i.samp_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Divider and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dvd_q <= {prod, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_next;
      quo_q <= {quo_q[SCORE_W-2:0], ge};
    end
    if (cmd_i.capture) begin
      rslot_q <= rand_slot_i;
      rcoin_q <= rand_coin_i;
    end
  end

  // Weight store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && item_cnt_q < MAX_C) wmem[item_cnt_q[IDX_W-1:0]] <= weight_i;
    if (cmd_i.w_read) w_rd_q <= wmem[scan_i_q[IDX_W-1:0]];
  end

  // Poor and rich stacks
  always_ff @(posedge clk_i) begin
    if (poor_we) poor_m[poor_wa] <= poor_wd;
    if (cmd_i.pop_read) poor_rd_q <= poor_m[IDX_W'(np_q - 1'b1)];
  end

  always_ff @(posedge clk_i) begin
    if (rich_we) rich_m[rich_wa] <= rich_wd;
    if (cmd_i.pop_read) rich_rd_q <= rich_m[IDX_W'(nr_q - 1'b1)];
  end

  // Sample slot: rand_slot times cell count, clamped
  logic [RW+CCNT_W-1:0] sprod;
  logic [CCNT_W-1:0]    slot_raw, slot;

  assign sprod    = rslot_q * cell_cnt_q;
  assign slot_raw = sprod[RW +: CCNT_W];
  assign slot     = (slot_raw >= cell_cnt_q) ? cell_cnt_q - 1'b1 : slot_raw;

  // Alias table
  always_ff @(posedge clk_i) begin
    if (cell_we) tbl_m[cell_cnt_q[TADDR_W-1:0]] <= cell_wd;
    if (cmd_i.samp_read) cell_rd_q <= tbl_m[slot[TADDR_W-1:0]];
  end

  // Coin scaled to the threshold format and cell pick
  logic [COIN_W-1:0] coin_wide;
  logic [THR_W-1:0]  coin, c_thr;
  logic [IDX_W-1:0]  c_prim, c_alias, pick;
  logic              c_has;

  assign coin_wide = {rcoin_q, {FRAC_BITS{1'b0}}} >> RW;
  assign coin      = THR_W'(coin_wide);
  assign c_prim    = cell_rd_q[CELL_W-1 -: IDX_W];
  assign c_thr     = cell_rd_q[IDX_W+1 +: THR_W];
  assign c_alias   = cell_rd_q[1 +: IDX_W];
  assign c_has     = cell_rd_q[0];
  assign pick      = (coin <= c_thr || !c_has) ? c_prim : c_alias;

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.report || cmd_i.samp_out) begin
      kind_q    <= cmd_i.report ? ats_pkg::KIND_REPORT : ats_pkg::KIND_SAMPLE;
      empty_q   <= cell_cnt_q == '0;
      ctot_q    <= ats_pkg::CTOT_W'(cell_cnt_q);
      ovf_out_q <= ovf_q;
      sidx_q    <= (cmd_i.report || cell_cnt_q == '0) ? '0 : ats_pkg::SIDX_W'(pick);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign sample_index_o = sidx_q;
  assign table_empty_o  = empty_q;
  assign cell_total_o   = ctot_q;
  assign overflow_o     = ovf_out_q;

  // Status
  always_comb begin
    sts_o              = '0;
    sts_o.in_valid     = in_valid_i;
    sts_o.in_opcode    = opcode_i;
    sts_o.in_last      = last_weight_i;
    sts_o.sum_zero     = sum_q == '0;
    sts_o.scan_done    = scan_i_q >= item_cnt_q;
    sts_o.w_zero       = w_rd_q == '0;
    sts_o.div_done     = bit_q == BIT_LAST;
    sts_o.stacks_empty = !have_p && !have_r;
    sts_o.table_full   = full;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

@@ rtl/alias_table_sampler_core.sv @@
// Top level of the alias table sampler: controller, datapath and channel hookup.
// Walker/Vose alias sampler in Q(FRAC_BITS) fixed point. A load transfer is accepted
// back to back. The load marked last starts a build that holds off input: a start step,
// then per stored weight a weight read and, if nonzero, a multiply, a division by the
// restoring divider that yields one score bit per cycle and a push on a stack; after
// the scan, a stack pop and table write per cell until the stacks are empty or the
// table is full; then the report, held back while the output register is occupied.
// An all-zero vector goes from the start step straight to the report. A sample goes
// through capture, registered alias table read, then compare and result. Results wait
// in an output register; the block returns to idle once a result is loaded there.
module alias_table_sampler_core #(
  parameter int unsigned MAX_ITEMS   = ats_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TABLE_DEPTH = ats_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = ats_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ats_in_if.sink    item_i,
  ats_out_if.source result_o
);

  ats_pkg::cmd_t cmd;
  ats_pkg::sts_t sts;
  logic          in_ready;

  assign item_i.ready = in_ready;

  // Sequencing
  ats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // Storage and arithmetic
  ats_datapath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_i     (item_i.valid),
    .opcode_i       (item_i.opcode),
    .weight_i       (item_i.weight),
    .last_weight_i  (item_i.last_weight),
    .rand_slot_i    (item_i.rand_slot),
    .rand_coin_i    (item_i.rand_coin),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .result_kind_o  (result_o.result_kind),
    .sample_index_o (result_o.sample_index),
    .table_empty_o  (result_o.table_empty),
    .cell_total_o   (result_o.cell_total),
    .overflow_o     (result_o.overflow)
  );

endmodule

@@ rtl/ats_checker.sv @@
// Port-level checks of the alias table sampler and their binding to the top level.
module ats_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_opcode_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_kind_i,
  input logic [ats_pkg::SIDX_W-1:0]   out_index_i,
  input logic                         out_empty_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i) &&
      $stable(out_kind_i) && $stable(out_empty_i))
    else $error("result changed while stalled");

  // An empty table never reports an index
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_index_i == '0)
    else $error("index nonzero on empty table");

  // A sample transfer blocks the next input for its table read
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_opcode_i == ats_pkg::OP_SAMPLE |=> !in_ready_i)
    else $error("input ready right after a sample");

  // A plain load leaves the input open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_opcode_i == ats_pkg::OP_LOAD && !in_last_i |=> in_ready_i)
    else $error("input blocked after a plain load");

endmodule

bind alias_table_sampler_core ats_checker u_ats_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .in_opcode_i (item_i.opcode),
  .in_last_i   (item_i.last_weight),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_kind_i  (result_o.result_kind),
  .out_index_i (result_o.sample_index),
  .out_empty_i (result_o.table_empty)
);
